// ===== hdl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Stream find and replace: shared package
// Types and constants used by the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CMD_BYTES = 8;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } sfr_reg_idx_t;

    // One command from the front end: the bytes to send, how many, and
    // whether the end mark closes them.
    typedef struct packed {
        logic [CMD_BYTES-1:0][BYTE_W-1:0] data;
        logic [LEN_W-1:0]                 count;
        logic                             last;
    } sfr_cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              out_last;
    } sfr_res_t;

endpackage

// ===== hdl/sfr_fifo.sv =====
// ----------------------------------------------------------------------------
// Stream find and replace: small synchronous queue
// A register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module sfr_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/sfr_front.sv =====
// ----------------------------------------------------------------------------
// Stream find and replace: front end
// Holds the window of pending bytes, compares it with the pattern in parallel
// and turns each accepted byte into at most one output command.
// ----------------------------------------------------------------------------
module sfr_front import sfr_pkg::*; #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [CFG_W-1:0]          pattern_bytes,
    input  logic [LEN_W-1:0]          pattern_length,
    input  logic [CFG_W-1:0]          replacement_bytes,
    input  logic [LEN_W-1:0]          replacement_length,
    input  logic                      win_clear,
    input  logic                      accept,
    input  logic [BYTE_W-1:0]         in_byte,
    input  logic                      in_last,
    output logic                      cmd_push,
    output sfr_cmd_t                  cmd
);

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [BYTE_W-1:0] win_reg [MAX_PATTERN];
    logic [BYTE_W-1:0] win_next [MAX_PATTERN];
    logic [BYTE_W-1:0] new_win [MAX_PATTERN];
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     plen;
    logic [CW-1:0]     wc;
    logic [LEN_W-1:0]  rlen;
    logic              win_full;
    logic              match;

    always_comb
    begin
        if (pattern_length == '0)
        begin
            plen = CW'(1);
        end
        else if (pattern_length > LEN_W'(MAX_PATTERN))
        begin
            plen = CW'(MAX_PATTERN);
        end
        else
        begin
            plen = CW'(pattern_length);
        end
        rlen = (replacement_length > LEN_W'(CMD_BYTES)) ? LEN_W'(CMD_BYTES)
                                                         : replacement_length;
    end

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            new_win[k] = win_reg[k];
        end
        new_win[cnt_reg[IW-1:0]] = in_byte;
        wc       = cnt_reg + 1'b1;
        win_full = (wc == plen);
        match    = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if ((CW'(k) < plen) && (new_win[k] != pattern_bytes[k*BYTE_W +: BYTE_W]))
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        cmd.data  = '0;
        cmd.count = '0;
        cmd.last  = in_last;
        cnt_next  = cnt_reg;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            win_next[k] = new_win[k];
        end
        if (win_full && match)
        begin
            cmd.data  = replacement_bytes;
            cmd.count = rlen;
            cnt_next  = '0;
        end
        else if (in_last)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                cmd.data[k] = new_win[k];
            end
            cmd.count = LEN_W'(wc);
            cnt_next  = '0;
        end
        else if (win_full)
        begin
            cmd.data[0] = new_win[0];
            cmd.count   = LEN_W'(1);
            cnt_next    = plen - 1'b1;
            for (int k = 0; k < MAX_PATTERN - 1; k++)
            begin
                win_next[k] = new_win[k + 1];
            end
        end
        else
        begin
            cnt_next = wc;
        end
        cmd_push = accept && (in_last || (cmd.count != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (win_clear)
        begin
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

endmodule

// ===== hdl/sfr_back.sv =====
// ----------------------------------------------------------------------------
// Stream find and replace: back end
// Expands each command into single result transfers, one per cycle while the
// result queue has room, and a bare end mark for a byteless closing command.
// ----------------------------------------------------------------------------
module sfr_back import sfr_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  sfr_cmd_t cmd,
    input  logic     cmd_empty,
    output logic     cmd_pop,
    input  logic     res_full,
    output logic     res_push,
    output sfr_res_t res
);

    localparam int IDX_W = $clog2(CMD_BYTES);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             at_end;
    logic             bare;

    always_comb
    begin
        bare     = (cmd.count == '0);
        at_end   = bare || (LEN_W'(idx_reg) == cmd.count - 1'b1);
        res_push = !cmd_empty && !res_full;
        cmd_pop  = res_push && at_end;
        res.out_byte  = bare ? '0 : cmd.data[idx_reg];
        res.out_valid = !bare;
        res.out_last  = cmd.last && at_end;
        idx_next = idx_reg;
        if (res_push)
        begin
            idx_next = at_end ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== hdl/stream_find_replace_top.sv =====
// ----------------------------------------------------------------------------
// Stream find and replace: top level
// Replaces every leftmost, non-overlapping occurrence of a pattern in a byte
// stream with a replacement; all other bytes pass through unchanged.
//
//   Channel   Handshake            Payload
//   input     push / full          in_byte, in_last
//   result    empty / pop          out_byte, out_valid, out_last
//   config    cfg_we               cfg_index, cfg_data
//
// One byte is accepted per cycle while the command queue has room.
// Each accepted byte yields zero to eight results; the back end sends one
// result per cycle while the result queue has room, finishing each byte first.
// The first result of a byte passes through both queues. Reset empties them,
// zeroes the window count and settings, and sets the pattern length to one.
// ----------------------------------------------------------------------------
module stream_find_replace_top import sfr_pkg::*; #(
    parameter int MAX_PATTERN = 8,
    parameter int CMD_DEPTH   = 2,
    parameter int OUT_DEPTH   = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [BYTE_W-1:0]    in_byte,
    input  logic                 in_last,
    output logic                 empty,
    input  logic                 pop,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 out_valid,
    output logic                 out_last
);

    logic [CFG_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0] pattern_length_reg;
    logic [CFG_W-1:0] replacement_bytes_reg;
    logic [LEN_W-1:0] replacement_length_reg;

    logic     accept;
    logic     win_clear;
    logic     cmd_push, cmd_pop, cmd_full, cmd_empty;
    sfr_cmd_t cmd_in, cmd_out;
    logic     res_push, res_full;
    sfr_res_t res_in, res_out;

    assign accept    = push && !full;
    assign full      = cmd_full;
    assign win_clear = cfg_we && (sfr_reg_idx_t'(cfg_index) == REG_PATTERN_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= LEN_W'(1);
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (sfr_reg_idx_t'(cfg_index))
                REG_PATTERN_BYTES:      pattern_bytes_reg      <= cfg_data;
                REG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_data[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg_data;
                REG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_data[LEN_W-1:0];
                default:                pattern_bytes_reg      <= pattern_bytes_reg;
            endcase
        end
    end

    sfr_front #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .pattern_bytes     (pattern_bytes_reg),
        .pattern_length    (pattern_length_reg),
        .replacement_bytes (replacement_bytes_reg),
        .replacement_length(replacement_length_reg),
        .win_clear         (win_clear),
        .accept            (accept),
        .in_byte           (in_byte),
        .in_last           (in_last),
        .cmd_push          (cmd_push),
        .cmd               (cmd_in)
    );

    sfr_fifo #(
        .DEPTH(CMD_DEPTH),
        .WIDTH($bits(sfr_cmd_t))
    ) u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_data(cmd_in),
        .rd_en  (cmd_pop),
        .rd_data(cmd_out),
        .full   (cmd_full),
        .empty  (cmd_empty)
    );

    sfr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_out),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    sfr_fifo #(
        .DEPTH(OUT_DEPTH),
        .WIDTH($bits(sfr_res_t))
    ) u_res_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_push),
        .wr_data(res_in),
        .rd_en  (pop),
        .rd_data(res_out),
        .full   (res_full),
        .empty  (empty)
    );

    assign out_byte  = res_out.out_byte;
    assign out_valid = res_out.out_valid;
    assign out_last  = res_out.out_last;

endmodule

// ===== tb/sfr_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream find and replace: result checker
// Watches the configuration, input and result channels of the block. It keeps
// its own copy of the registers and the byte window, works out the results
// that each accepted input byte must cause, and compares every result
// transfer, field by field, with the oldest one still awaited.
// ----------------------------------------------------------------------------
module sfr_result_checker import sfr_pkg::*; #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 push,
    input  logic                 full,
    input  logic [BYTE_W-1:0]    in_byte,
    input  logic                 in_last,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [BYTE_W-1:0]    out_byte,
    input  logic                 out_valid,
    input  logic                 out_last,
    output int unsigned          errors,
    output int unsigned          pending,
    output int unsigned          results_checked,
    output int unsigned          matches_seen
);

    logic [CFG_W-1:0]  pattern;
    logic [LEN_W-1:0]  pattern_len;
    logic [CFG_W-1:0]  replacement;
    logic [LEN_W-1:0]  replacement_len;
    logic [BYTE_W-1:0] window [MAX_PATTERN];
    int unsigned       window_fill;
    sfr_res_t          awaited_results [$];
    int unsigned       error_count;
    int unsigned       result_count;
    int unsigned       match_count;

    function automatic int unsigned clamp_len(input logic [LEN_W-1:0] value,
                                              input int unsigned lo,
                                              input int unsigned hi);
        if (value < lo)
        begin
            return lo;
        end
        if (value > hi)
        begin
            return hi;
        end
        return value;
    endfunction

    task automatic add_result(input logic [BYTE_W-1:0] value, input logic valid);
        sfr_res_t res;
        res.out_byte  = value;
        res.out_valid = valid;
        res.out_last  = 1'b0;
        awaited_results.push_back(res);
    endtask

    task automatic find_replace(input logic [BYTE_W-1:0] value, input logic closes);
        int unsigned plen;
        int unsigned rlen;
        int unsigned queued_before;
        int unsigned k;
        logic        hit;
        sfr_res_t    tail;
        plen = clamp_len(pattern_len, 1, MAX_PATTERN);
        rlen = clamp_len(replacement_len, 0, CMD_BYTES);
        queued_before = awaited_results.size();
        if (window_fill >= plen)
        begin
            window_fill = 0;
        end
        window[window_fill] = value;
        window_fill++;
        if (window_fill == plen)
        begin
            hit = 1'b1;
            for (k = 0; k < plen; k++)
            begin
                if (window[k] !== pattern[8*k +: 8])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                match_count++;
                for (k = 0; k < rlen; k++)
                begin
                    add_result(replacement[8*k +: 8], 1'b1);
                end
                window_fill = 0;
            end
            else
            begin
                add_result(window[0], 1'b1);
                for (k = 1; k < window_fill; k++)
                begin
                    window[k-1] = window[k];
                end
                window_fill--;
            end
        end
        if (closes)
        begin
            for (k = 0; k < window_fill; k++)
            begin
                add_result(window[k], 1'b1);
            end
            window_fill = 0;
            if (awaited_results.size() == queued_before)
            begin
                add_result(8'h00, 1'b0);
            end
            tail = awaited_results.pop_back();
            tail.out_last = 1'b1;
            awaited_results.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        sfr_res_t seen;
        sfr_res_t wanted;
        if (!rst_n)
        begin
            pattern         = '0;
            pattern_len     = 4'd1;
            replacement     = '0;
            replacement_len = '0;
            window_fill     = 0;
            awaited_results.delete();
            error_count     = 0;
            result_count    = 0;
            match_count     = 0;
            errors          <= 0;
            pending         <= 0;
            results_checked <= 0;
            matches_seen    <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                seen.out_byte  = out_byte;
                seen.out_valid = out_valid;
                seen.out_last  = out_last;
                result_count++;
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("Unexpected result %0d: byte %h valid %b last %b",
                                 result_count, seen.out_byte, seen.out_valid,
                                 seen.out_last);
                    end
                end
                else
                begin
                    wanted = awaited_results.pop_front();
                    if (seen.out_valid !== wanted.out_valid
                        || seen.out_last !== wanted.out_last
                        || (wanted.out_valid && seen.out_byte !== wanted.out_byte))
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display({"Result %0d mismatch: expected byte %h valid %b ",
                                      "last %b, got byte %h valid %b last %b"},
                                     result_count, wanted.out_byte, wanted.out_valid,
                                     wanted.out_last, seen.out_byte, seen.out_valid,
                                     seen.out_last);
                        end
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PATTERN_BYTES:
                    begin
                        pattern = cfg_data;
                    end
                    REG_PATTERN_LENGTH:
                    begin
                        pattern_len = cfg_data[LEN_W-1:0];
                        window_fill = 0;
                    end
                    REG_REPLACEMENT_BYTES:
                    begin
                        replacement = cfg_data;
                    end
                    REG_REPLACEMENT_LENGTH:
                    begin
                        replacement_len = cfg_data[LEN_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (push && !full)
            begin
                find_replace(in_byte, in_last);
            end
            errors          <= error_count;
            pending         <= awaited_results.size();
            results_checked <= result_count;
            matches_seen    <= match_count;
        end
    end

endmodule

// ===== tb/stream_find_replace_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream find and replace: testbench top
// Drives directed streams at the register and byte extremes, then phases of
// random configurations with streams built mostly from whole and partial
// pattern occurrences. Both channels idle at random. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module stream_find_replace_top_test;
    import sfr_pkg::*;

    localparam int          MAX_PATTERN = 8;
    localparam int unsigned ITEM_TARGET = 270;
    localparam int unsigned PHASE_BYTES = 24;
    localparam int unsigned SETTLE_GAP  = 16;
    localparam int unsigned CYCLE_LIMIT = 300000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_PATTERN_BYTES;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 push      = 1'b0;
    logic                 full;
    logic [BYTE_W-1:0]    in_byte   = '0;
    logic                 in_last   = 1'b0;
    logic                 empty;
    logic                 pop       = 1'b0;
    logic [BYTE_W-1:0]    out_byte;
    logic                 out_valid;
    logic                 out_last;

    int unsigned errors;
    int unsigned pending;
    int unsigned results_checked;
    int unsigned matches_seen;
    int unsigned bytes_sent  = 0;
    int unsigned configs     = 0;
    int unsigned push_calm   = 0;
    int unsigned pop_calm    = 0;
    int unsigned cycle_count = 0;

    stream_find_replace_top #(
        .MAX_PATTERN(MAX_PATTERN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .push     (push),
        .full     (full),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .out_valid(out_valid),
        .out_last (out_last)
    );

    sfr_result_checker #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .in_byte        (in_byte),
        .in_last        (in_last),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .out_valid      (out_valid),
        .out_last       (out_last),
        .errors         (errors),
        .pending        (pending),
        .results_checked(results_checked),
        .matches_seen   (matches_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly a random gap, with the odd stretch of none.
    function automatic int unsigned draw_gap(inout int unsigned calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic closes);
        int unsigned gap;
        gap = draw_gap(push_calm);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_byte <= value;
        in_last <= closes;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Holds the input back until every awaited result has been transferred.
    task automatic settle(input int unsigned extra);
        push <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (extra + 1) @(posedge clk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] pat, input logic [LEN_W-1:0] plen,
                               input logic [CFG_W-1:0] rep, input logic [LEN_W-1:0] rlen);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PATTERN_BYTES;
        cfg_data  <= pat;
        @(posedge clk);
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_data  <= CFG_W'(plen);
        @(posedge clk);
        cfg_index <= REG_REPLACEMENT_BYTES;
        cfg_data  <= rep;
        @(posedge clk);
        cfg_index <= REG_REPLACEMENT_LENGTH;
        cfg_data  <= CFG_W'(rlen);
        @(posedge clk);
        cfg_we <= 1'b0;
        configs++;
    endtask

    initial
    begin : drain_results
        int unsigned gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(pop_calm);
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0]  pat;
        logic [CFG_W-1:0]  rep;
        logic [LEN_W-1:0]  plen;
        logic [LEN_W-1:0]  rlen;
        logic [BYTE_W-1:0] alphabet [3];
        logic [BYTE_W-1:0] stream_q [$];
        int unsigned       eff_len;
        int unsigned       target;
        int unsigned       kind;
        int unsigned       cut;
        int unsigned       phase_bytes;
        int unsigned       k;
        logic              open_end;
        logic              closes;

        wait (rst_n);
        @(posedge clk);

        // Reset settings delete every zero byte; a lone zero leaves only the end mark.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle(SETTLE_GAP);

        // Two-byte pattern expanding to the longest replacement.
        load_config(64'h0000_0000_0000_6261, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b1);
        // Left in the window; the next length write must discard it.
        send_byte(8'h61, 1'b0);
        settle(SETTLE_GAP);

        // Out-of-range lengths: zero pattern length and an oversized replacement.
        load_config(64'h0000_0000_0000_00FF, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd15);
        send_byte(8'hFF, 1'b1);
        settle(SETTLE_GAP);

        // Oversized pattern length: eight zero bytes deleted, bare end mark.
        load_config(64'h0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        for (k = 0; k < 8; k++)
        begin
            send_byte(8'h00, k == 7);
        end
        settle(SETTLE_GAP);

        while (bytes_sent < ITEM_TARGET)
        begin
            for (k = 0; k < 3; k++)
            begin
                alphabet[k] = BYTE_W'($urandom_range(0, 255));
            end
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                plen = 4'd0;
            end
            else if (kind == 1)
            begin
                plen = LEN_W'($urandom_range(9, 15));
            end
            else if (kind < 4)
            begin
                plen = 4'd8;
            end
            else
            begin
                plen = LEN_W'($urandom_range(1, 5));
            end
            eff_len = (plen == 0) ? 1 : ((plen > 8) ? 8 : plen);
            pat = {$urandom, $urandom};
            for (k = 0; k < eff_len; k++)
            begin
                pat[8*k +: 8] = alphabet[$urandom_range(0, 2)];
            end
            rep  = {$urandom, $urandom};
            rlen = LEN_W'($urandom_range(0, 15));
            load_config(pat, plen, rep, rlen);

            open_end    = ($urandom_range(0, 3) == 0);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                target = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 16);
                stream_q.delete();
                while (stream_q.size() < target)
                begin
                    kind = $urandom_range(0, 9);
                    if (kind < 4)
                    begin
                        for (k = 0; k < eff_len; k++)
                        begin
                            stream_q.push_back(pat[8*k +: 8]);
                        end
                    end
                    else if (kind < 6)
                    begin
                        cut = (eff_len > 1) ? $urandom_range(1, eff_len - 1) : 0;
                        for (k = 0; k < cut; k++)
                        begin
                            stream_q.push_back(pat[8*k +: 8]);
                        end
                        stream_q.push_back(alphabet[$urandom_range(0, 2)]);
                    end
                    else if (kind < 9)
                    begin
                        stream_q.push_back(alphabet[$urandom_range(0, 2)]);
                    end
                    else
                    begin
                        stream_q.push_back(BYTE_W'($urandom_range(0, 255)));
                    end
                end
                closes = !(open_end && phase_bytes + stream_q.size() >= PHASE_BYTES);
                for (k = 0; k < stream_q.size(); k++)
                begin
                    send_byte(stream_q[k], closes && k == stream_q.size() - 1);
                end
                phase_bytes += stream_q.size();
                if ($urandom_range(0, 5) == 0)
                begin
                    settle(0);
                end
            end
            settle(SETTLE_GAP);
        end

        settle(2 * SETTLE_GAP);
        $display("Sent %0d bytes under %0d register settings; %0d results checked, %0d matches.",
                 bytes_sent, configs, results_checked, matches_seen);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
